// ===== rtl/core/sss_pkg.sv =====
// Shared types and codes for the streaming substring search unit.
// No dependencies; imported by sss_cell and streaming_substring_search_unit.
`default_nettype none

package sss_pkg;

  typedef enum logic [1:0] {
    CMD_NEW    = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_TEXT   = 2'd2,
    CMD_END    = 2'd3
  } sss_cmd_t;

  localparam logic [1:0] ST_NOMATCH  = 2'd0;
  localparam logic [1:0] ST_MATCH    = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  // Broadcast from the controller to every cell of the chain.
  typedef struct packed {
    logic       clear;  // new pattern: drop partial matches and the end mark
    logic       load;   // a pattern byte is written this cycle
    logic       shift;  // a text byte enters the chain this cycle
    logic [7:0] data;   // pattern or text byte
  } sss_cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/sss_cell.sv =====
// One cell of the match chain: one pattern byte plus a partial-match flag.
// Depends on sss_pkg.
`default_nettype none

module sss_cell
  import sss_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire sss_cell_ctrl_t ctrl,
  input  wire logic           sel,        // this cell is the next free pattern slot
  input  wire logic           prev_flag,  // neighbour's flag, previous text byte
  output logic                flag,       // pattern[0..j] ends at newest byte
  output logic                last,       // this cell holds the final pattern byte
  output logic                hit         // whole pattern ends at the incoming byte
);

  logic [7:0] pat;
  logic       flag_next;

  assign flag_next = prev_flag && (ctrl.data == pat);
  assign hit       = ctrl.shift && flag_next && last;

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      flag <= 1'b0;
      last <= 1'b0;
    end else begin
      if (ctrl.load) begin
        last <= sel;
      end
      if (ctrl.shift) begin
        flag <= flag_next;
      end
    end
  end

  // pattern byte, no reset: only read once written
  always_ff @(posedge clk) begin
    if (ctrl.load && sel) begin
      pat <= ctrl.data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/streaming_substring_search_unit.sv =====
// Top level of the streaming substring search unit: controller, cell chain
// and result register. Depends on sss_pkg and sss_cell.
// A result word is registered and appears on the output in the cycle after the word that causes it.
// Throughput: one input word per cycle; input stalls only while a result is held.
// Rate set by the cell chain: each cell compares its pattern byte once per text byte.
// Reset (rst, synchronous): empty pattern, counters and flags cleared, output empty.
`default_nettype none

module streaming_substring_search_unit
  import sss_pkg::*;
#(
  parameter int MAX_PATTERN   = 32,
  parameter int POSITION_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  cmd,
  input  wire logic [7:0]  data_byte,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status,
  output logic [31:0]      match_position
);

  localparam int LW = $clog2(MAX_PATTERN + 1);
  localparam int CW = (POSITION_BITS > LW) ? POSITION_BITS : LW;

  // search state
  logic [LW-1:0]            len;
  logic                     overflow;
  logic [POSITION_BITS-1:0] bytes_seen;
  logic                     done;
  logic                     started;

  logic                     accept;
  sss_cmd_t                 op;
  logic                     is_text;
  logic                     do_append;
  logic                     do_shift;
  sss_cell_ctrl_t           ctrl;

  logic [MAX_PATTERN-1:0]   flags;
  logic [MAX_PATTERN-1:0]   lasts;
  logic [MAX_PATTERN-1:0]   hits;
  logic [MAX_PATTERN-1:0]   sels;

  logic [POSITION_BITS-1:0] bytes_seen_next;
  logic [CW-1:0]            pos_full;
  logic                     pattern_hit;

  // result staging
  logic                     out_load;
  logic [1:0]               status_next;
  logic [31:0]              position_next;

  // The output register is the only buffer: while it holds an untaken word
  // the input waits, otherwise a word is taken every cycle.
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign op       = sss_cmd_t'(cmd);
  assign is_text  = (op == CMD_TEXT) || (op == CMD_END);

  // Pattern bytes count only before the first text word; zero bytes are skipped.
  assign do_append = accept && (op == CMD_APPEND) && (data_byte != 8'd0) && !started;

  // A real text byte shifts the chain; overflow, empty pattern and end of
  // text finish the search instead.
  assign do_shift = accept && (op == CMD_TEXT) && !done && !overflow
                    && (len != '0) && (data_byte != 8'd0);

  always_comb begin
    ctrl.clear = accept && (op == CMD_NEW);
    ctrl.load  = do_append && (len < LW'(MAX_PATTERN));
    ctrl.shift = do_shift;
    ctrl.data  = data_byte;
  end

  // Chain of cells: cell j keeps pattern byte j and a flag that says the
  // newest text bytes end with pattern[0..j]; flags move one cell per byte.
  genvar j;
  generate
    for (j = 0; j < MAX_PATTERN; j++) begin : g_cell
      logic prev;
      if (j == 0) begin : g_head
        assign prev = 1'b1;
      end else begin : g_link
        assign prev = flags[j-1];
      end
      assign sels[j] = (len == LW'(j));
      sss_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctrl      (ctrl),
        .sel       (sels[j]),
        .prev_flag (prev),
        .flag      (flags[j]),
        .last      (lasts[j]),
        .hit       (hits[j])
      );
    end
  endgenerate

  // Saturating count of text bytes, including the incoming one.
  assign bytes_seen_next = (&bytes_seen) ? bytes_seen : bytes_seen + 1'b1;

  // Once saturated, the count can fall below the pattern length; no match then.
  assign pattern_hit = (|hits) && (CW'(len) <= CW'(bytes_seen_next));
  assign pos_full    = CW'(bytes_seen_next) - CW'(len);

  // Result selection, in the order the cases take priority.
  always_comb begin
    out_load      = 1'b0;
    status_next   = ST_NOMATCH;
    position_next = '0;
    if (accept && is_text && !done) begin
      if (overflow) begin
        out_load    = 1'b1;
        status_next = ST_OVERFLOW;
      end else if (len == '0) begin
        out_load    = 1'b1;
        status_next = ST_MATCH;
      end else if ((op == CMD_END) || (data_byte == 8'd0)) begin
        out_load    = 1'b1;
        status_next = ST_NOMATCH;
      end else if (pattern_hit) begin
        out_load      = 1'b1;
        status_next   = ST_MATCH;
        position_next = 32'(pos_full);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len        <= '0;
      overflow   <= 1'b0;
      bytes_seen <= '0;
      done       <= 1'b0;
      started    <= 1'b0;
    end else if (accept) begin
      case (op)
        CMD_NEW: begin
          len        <= '0;
          overflow   <= 1'b0;
          bytes_seen <= '0;
          done       <= 1'b0;
          started    <= 1'b0;
        end
        CMD_APPEND: begin
          if (do_append) begin
            if (len < LW'(MAX_PATTERN)) begin
              len <= len + 1'b1;
            end else begin
              overflow <= 1'b1;
            end
          end
        end
        CMD_TEXT, CMD_END: begin
          if (!done) begin
            started <= 1'b1;
          end
          if (do_shift) begin
            bytes_seen <= bytes_seen_next;
          end
          if (out_load) begin
            done <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status         <= status_next;
      match_position <= position_next;
    end
  end

`ifndef SYNTHESIS
  // at most one cell marks the pattern end
  a_one_last: assert property (@(posedge clk) disable iff (rst) $onehot0(lasts))
    else $error("more than one cell marked as pattern end");

  // no cell carries the end mark while the pattern is empty
  a_last_len: assert property (@(posedge clk) disable iff (rst)
    (len == '0) |-> (lasts == '0))
    else $error("end mark present with empty pattern");

  // every result ends the search
  a_done_after: assert property (@(posedge clk) disable iff (rst)
    out_load |=> done)
    else $error("result given without ending the search");

  // only a match carries a position
  a_pos_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != ST_MATCH)) |-> (match_position == 32'd0))
    else $error("nonzero position on a non-match result");

  // the stored length never passes the chain length
  a_len_range: assert property (@(posedge clk) disable iff (rst)
    len <= LW'(MAX_PATTERN))
    else $error("pattern length beyond chain");
`endif

endmodule

`default_nettype wire

// ===== verif/streaming_substring_search_unit_checker.sv =====
// Checker for the streaming substring search unit: it watches both channels,
// keeps its own search state and compares each result word as it leaves.
// Depends on sss_pkg for the command and status codes.
module streaming_substring_search_unit_checker
  import sss_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [1:0]  cmd,
  input  wire logic [7:0]  data_byte,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [1:0]  status,
  input  wire logic [31:0] match_position,
  output int               error_count,
  output int               reports_due,
  output int               match_count,
  output int               miss_count,
  output int               overflow_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PAT_DEPTH = 32;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] position;
  } search_report_t;

  logic [7:0]     pattern_bytes [PAT_DEPTH];
  logic [5:0]     pattern_len;
  bit             pattern_too_long;
  logic [7:0]     recent_text [PAT_DEPTH];  // [0] is the newest text byte
  logic [31:0]    text_count;               // saturates; never reached in a run
  bit             text_begun;
  bit             search_over;
  search_report_t reports_owed [$];
  search_report_t want;

  int errors = 0;
  int owed_now = 0;
  int n_match = 0;
  int n_miss = 0;
  int n_overflow = 0;

  assign error_count    = errors;
  assign reports_due    = owed_now;
  assign match_count    = n_match;
  assign miss_count     = n_miss;
  assign overflow_count = n_overflow;

  task automatic clear_search();
    foreach (recent_text[k]) recent_text[k] = 8'h00;
    text_count  = '0;
    text_begun  = 1'b0;
    search_over = 1'b0;
  endtask

  task automatic report(input logic [1:0] st, input logic [31:0] pos);
    reports_owed.push_back('{status: st, position: pos});
    search_over = 1'b1;
  endtask

  task automatic absorb_word(input logic [1:0] c, input logic [7:0] b);
    bit hit;
    int k;
    case (sss_cmd_t'(c))
      CMD_NEW: begin
        pattern_len      = '0;
        pattern_too_long = 1'b0;
        clear_search();
      end
      CMD_APPEND: begin
        // zero bytes and bytes after text has started leave the pattern alone
        if (b != 8'h00 && !text_begun) begin
          if (pattern_len >= PAT_DEPTH) begin
            pattern_too_long = 1'b1;
          end else begin
            pattern_bytes[pattern_len] = b;
            pattern_len++;
          end
        end
      end
      default: begin
        if (!search_over) begin
          text_begun = 1'b1;
          if (pattern_too_long) begin
            report(ST_OVERFLOW, '0);
          end else if (pattern_len == 0) begin
            report(ST_MATCH, '0);
          end else if (sss_cmd_t'(c) == CMD_END || b == 8'h00) begin
            report(ST_NOMATCH, '0);
          end else begin
            for (k = PAT_DEPTH - 1; k > 0; k--) recent_text[k] = recent_text[k - 1];
            recent_text[0] = b;
            if (text_count != '1) text_count++;
            hit = (text_count >= pattern_len);
            for (k = 0; k < pattern_len; k++) begin
              if (recent_text[k] != pattern_bytes[pattern_len - 1 - k]) hit = 1'b0;
            end
            if (hit) report(ST_MATCH, text_count - pattern_len);
          end
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pattern_len      = '0;
      pattern_too_long = 1'b0;
      clear_search();
      reports_owed.delete();
    end else begin
      if (in_valid && !in_stall) absorb_word(cmd, data_byte);
      if (out_valid && !out_stall) begin
        if (reports_owed.size() == 0) begin
          errors++;
          $display("%0t: result with none due: status %0d position %0d",
                   $time, status, match_position);
        end else begin
          want = reports_owed.pop_front();
          if (status !== want.status) begin
            errors++;
            $display("%0t: status expected %0d, got %0d", $time, want.status, status);
          end
          if (match_position !== want.position) begin
            errors++;
            $display("%0t: match_position expected %0d, got %0d",
                     $time, want.position, match_position);
          end
          case (want.status)
            ST_MATCH:    n_match++;
            ST_OVERFLOW: n_overflow++;
            default:     n_miss++;
          endcase
        end
      end
    end
    owed_now = reports_owed.size();
  end

endmodule

// ===== verif/streaming_substring_search_unit_tb.sv =====
// Testbench top for the streaming substring search unit: clock, reset, word
// stimulus and receiver stalls; checking is done by the checker module.
// Depends on sss_pkg, streaming_substring_search_unit and its checker.
module streaming_substring_search_unit_tb;
  import sss_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Rough count of input words that do real work; words the block simply
  // drops after a finished search are not counted towards it.
  localparam int WORD_TARGET = 1750;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  cmd = CMD_NEW;
  logic [7:0]  data_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [31:0] match_position;

  int error_count;
  int reports_due;
  int match_count;
  int miss_count;
  int overflow_count;

  int words_sent = 0;
  int ignored_words = 0;
  int searches = 0;
  int recv_wait = 0;
  bit calm = 1'b0;  // set for whole searches: no gaps and no stalls

  always #5 clk = ~clk;

  streaming_substring_search_unit DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .cmd            (cmd),
    .data_byte      (data_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .match_position (match_position)
  );

  streaming_substring_search_unit_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .cmd            (cmd),
    .data_byte      (data_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .match_position (match_position),
    .error_count    (error_count),
    .reports_due    (reports_due),
    .match_count    (match_count),
    .miss_count     (miss_count),
    .overflow_count (overflow_count)
  );

  // Receiver: after each accepted result draw a random wait and hold stall through it;
  // when idle, stall now and then so a fresh result can meet a stall too.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) recv_wait = calm ? 0 : $urandom_range(0, 6);
  end

  always @(negedge clk) begin
    if (recv_wait > 0) begin
      out_stall <= 1'b1;
      recv_wait--;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 7) == 0);
    end
  end

  // One word on the input channel. Called just after a rising edge; every
  // change is made at a falling edge and each signal is written once per step.
  task automatic send_word(input sss_cmd_t c, input logic [7:0] b);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 6);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    cmd       <= c;
    data_byte <= b;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  // Hold the input until every predicted result has left the block.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (reports_due == 0);
  endtask

  // Narrow mode draws from two nearby symbols so partial matches are common.
  function automatic logic [7:0] pick_byte(input bit narrow, input logic [7:0] base);
    logic [7:0] v;
    v = narrow ? (base ^ 8'($urandom_range(0, 1))) : 8'($urandom_range(1, 255));
    if (v == 8'h00) v = base;
    return v;
  endfunction

  // One search: new pattern, pattern bytes, text with the pattern often
  // planted in it, an end mark and a few words that should be dropped.
  task automatic random_search();
    logic [7:0] pat [$];
    logic [7:0] base;
    int plen;
    int lead;
    int trail;
    int kind;
    bit narrow;
    kind = $urandom_range(0, 99);
    if (kind < 8) plen = $urandom_range(33, 36);        // overlong pattern
    else if (kind < 18) plen = $urandom_range(17, 32);  // deep window
    else if (kind < 25) plen = 0;                       // empty pattern
    else plen = $urandom_range(1, 6);
    narrow = $urandom_range(0, 1);
    base   = 8'($urandom_range(1, 255));
    calm   = ($urandom_range(0, 4) == 0);
    searches++;
    send_word(CMD_NEW, 8'($urandom));
    repeat (plen) begin
      if ($urandom_range(0, 11) == 0) send_word(CMD_APPEND, 8'h00);
      pat.push_back(pick_byte(narrow, base));
      send_word(CMD_APPEND, pat[$]);
    end
    // occasional noise word of any kind
    if ($urandom_range(0, 9) == 0) send_word(sss_cmd_t'($urandom_range(0, 3)), 8'($urandom));
    lead = (plen > 16) ? $urandom_range(0, 40) : $urandom_range(0, 10);
    repeat (lead) send_word(CMD_TEXT, pick_byte(narrow, base));
    // pattern byte arriving once text has begun
    if ($urandom_range(0, 9) == 0) send_word(CMD_APPEND, pick_byte(narrow, base));
    if ($urandom_range(0, 9) < 6) begin
      foreach (pat[i]) send_word(CMD_TEXT, pat[i]);
    end
    repeat ($urandom_range(0, 3)) send_word(CMD_TEXT, pick_byte(narrow, base));
    if ($urandom_range(0, 3) == 0) send_word(CMD_TEXT, 8'h00);
    else send_word(CMD_END, 8'($urandom));
    trail = $urandom_range(0, 2);
    ignored_words += trail;
    repeat (trail) send_word($urandom_range(0, 1) ? CMD_TEXT : CMD_END, 8'($urandom));
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty pattern matches at once; later text words are dropped
    send_word(CMD_NEW, 8'hFF);
    send_word(CMD_TEXT, 8'h61);
    send_word(CMD_TEXT, 8'h62);
    send_word(CMD_END, 8'h00);
    ignored_words += 2;
    // zero pattern byte ignored, extreme bytes, match after one byte
    send_word(CMD_NEW, 8'h00);
    send_word(CMD_APPEND, 8'h00);
    send_word(CMD_APPEND, 8'hFF);
    send_word(CMD_APPEND, 8'h01);
    send_word(CMD_TEXT, 8'h01);
    send_word(CMD_TEXT, 8'hFF);
    send_word(CMD_TEXT, 8'h01);
    // late pattern byte, then a zero text byte ends with no match
    send_word(CMD_NEW, 8'h55);
    send_word(CMD_APPEND, 8'h80);
    send_word(CMD_TEXT, 8'h7F);
    send_word(CMD_APPEND, 8'h7F);
    send_word(CMD_TEXT, 8'h00);
    // explicit end of text with no match
    send_word(CMD_NEW, 8'hAA);
    send_word(CMD_APPEND, 8'h55);
    send_word(CMD_TEXT, 8'hAA);
    send_word(CMD_END, 8'hFF);
    // empty pattern met by an end mark
    send_word(CMD_NEW, 8'h00);
    send_word(CMD_END, 8'h00);
    drain();

    while (words_sent - ignored_words < WORD_TARGET) begin
      if (searches % 8 == 7) drain();
      random_search();
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait (reports_due == 0);
    repeat (10) @(posedge clk);

    $display("ran %0d searches over %0d input words (%0d dropped after a result)",
             searches, words_sent, ignored_words);
    $display("results: %0d matches, %0d misses, %0d pattern overflows",
             match_count, miss_count, overflow_count);
    if (error_count == 0) begin
      $display("streaming_substring_search_unit_tb: done, clean");
    end else begin
      $display("streaming_substring_search_unit_tb: done, errors");
    end
    $finish;
  end

  // hang guard, far above the slowest legal run
  initial begin
    #5ms;
    $display("streaming_substring_search_unit_tb: done, errors");
    $finish;
  end

endmodule
